// ===== rtl/core/iee_pkg.sv =====
// Shared types, character codes and helpers for the infix expression evaluator.
`timescale 1ns / 1ps
package iee_pkg;

  typedef enum logic [2:0] {
    OPC_PAREN = 3'd0,
    OPC_ADD   = 3'd1,
    OPC_SUB   = 3'd2,
    OPC_MUL   = 3'd3,
    OPC_DIV   = 3'd4,
    OPC_XOR   = 3'd5,
    OPC_DICE  = 3'd6,
    OPC_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_DICE     = 2'd3
  } status_e;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DICE   = 8'h64;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [67:0] INT_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;

  // Request/response between sequencer and arithmetic unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  function automatic op_e char_to_op(logic [7:0] c);
    op_e o;
    o = OPC_NONE;
    if (c == CH_PLUS) o = OPC_ADD;
    else if (c == CH_MINUS) o = OPC_SUB;
    else if (c == CH_STAR) o = OPC_MUL;
    else if (c == CH_SLASH) o = OPC_DIV;
    else if (c == CH_CARET) o = OPC_XOR;
    else if (c == CH_DICE) o = OPC_DICE;
    return o;
  endfunction

  function automatic logic [2:0] prec(op_e o);
    logic [2:0] p;
    unique case (o)
      OPC_ADD, OPC_SUB: p = 3'd2;
      OPC_MUL, OPC_DIV: p = 3'd3;
      OPC_XOR:          p = 3'd4;
      OPC_DICE:         p = 3'd5;
      default:          p = 3'd1;
    endcase
    return p;
  endfunction

  function automatic status_e raise(status_e cur, status_e s);
    return (cur == ST_OK) ? s : cur;
  endfunction

endpackage

// ===== rtl/core/iee_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module iee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== rtl/core/iee_alu.sv =====
// Shared arithmetic unit: add/sub/xor registered directly on start, bit-serial multiply and divide.
`timescale 1ns / 1ps
module iee_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iee_pkg::alu_req_t req_i,
  input  logic [63:0]       lhs_i,
  input  logic [63:0]       rhs_i,
  output iee_pkg::alu_rsp_t rsp_o,
  output logic [63:0]       result_o
);
  logic        busy_q, is_div_q, neg_q, done_q, dz_q;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q, sh_q, opd_q, res_q;
  logic [63:0] acc_n, sh_n, mag_a, mag_b;
  logic [64:0] rem_sh, rem_sub;

  assign mag_a = lhs_i[63] ? (64'd0 - lhs_i) : lhs_i;
  assign mag_b = rhs_i[63] ? (64'd0 - rhs_i) : rhs_i;

  // one step of multiply (acc = product) or restoring divide (acc = remainder)
  always_comb begin
    rem_sh  = {acc_q, sh_q[63]};
    rem_sub = rem_sh - {1'b0, opd_q};
    if (is_div_q) begin
      if (!rem_sub[64]) begin
        acc_n = rem_sub[63:0];
        sh_n  = {sh_q[62:0], 1'b1};
      end else begin
        acc_n = rem_sh[63:0];
        sh_n  = {sh_q[62:0], 1'b0};
      end
    end else begin
      acc_n = sh_q[0] ? (acc_q + opd_q) : acc_q;
      sh_n  = {1'b0, sh_q[63:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      dz_q     <= 1'b0;
      cnt_q    <= '0;
      is_div_q <= 1'b0;
      neg_q    <= 1'b0;
      acc_q    <= '0;
      sh_q     <= '0;
      opd_q    <= '0;
      res_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dz_q  <= 1'b0;
        cnt_q <= '0;
        unique case (req_i.op)
          iee_pkg::OPC_ADD: begin res_q <= lhs_i + rhs_i; done_q <= 1'b1; end
          iee_pkg::OPC_SUB: begin res_q <= lhs_i - rhs_i; done_q <= 1'b1; end
          iee_pkg::OPC_XOR: begin res_q <= lhs_i ^ rhs_i; done_q <= 1'b1; end
          iee_pkg::OPC_MUL: begin
            acc_q    <= '0;
            opd_q    <= lhs_i;
            sh_q     <= rhs_i;
            is_div_q <= 1'b0;
            busy_q   <= 1'b1;
          end
          iee_pkg::OPC_DIV: begin
            if (rhs_i == 64'd0) begin
              res_q  <= '0;
              dz_q   <= 1'b1;
              done_q <= 1'b1;
            end else begin
              acc_q    <= '0;
              sh_q     <= mag_a;
              opd_q    <= mag_b;
              neg_q    <= lhs_i[63] ^ rhs_i[63];
              is_div_q <= 1'b1;
              busy_q   <= 1'b1;
            end
          end
          default: begin res_q <= '0; done_q <= 1'b1; end
        endcase
      end else if (busy_q) begin
        acc_q <= acc_n;
        sh_q  <= sh_n;
        if (is_div_q) begin
          opd_q <= opd_q;
        end else begin
          opd_q <= {opd_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (is_div_q) begin
            res_q <= neg_q ? (64'd0 - sh_n) : sh_n;
          end else begin
            res_q <= acc_n;
          end
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign result_o       = res_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("alu started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("alu done while busy");
  a_dz_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dz_q && done_q) |-> $past(req_i.start)) else $error("late divide-by-zero flag");
endmodule

// ===== rtl/core/infix_expression_evaluator.sv =====
// Top level: character parser, stack sequencer and result register.
`timescale 1ns / 1ps
// Infix expression evaluator.
// Input channel: in_valid_i / in_stall_o carry one ASCII character (char_code_i)
// and a flag last_i marking the final character. A transfer happens when valid is
// high and stall is low; stall is high whenever the sequencer is busy.
// Output channel: out_valid_o / out_stall_i carry result_o, status_o and
// values_left_o, one transfer per expression, produced after the last character.
// Sequencing: a digit, '.' or other character passes through decode and a
// last-character check. An operator or ')' reads and examines stack entries
// one at a time; each operator applied pops two values, runs in the shared unit
// and pushes its result, with '*' and '/' by a nonzero divisor taking the
// bit-serial path. The flush on the last character applies all remaining
// operators the same way, then reads the top value into the output register.
// Stacks live in two RAMs read through a registered port, so every stack read
// has its own read state; the shared arithmetic unit sets the long path.
// Reset clears counts, number state and status; stack contents are not cleared.
// If the receiver stalls a previous result, the next result waits in the
// sequencer (no further characters are taken) until the output register frees.
module infix_expression_evaluator #(
  parameter int OP_DEPTH    = 16,
  parameter int VALUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic [1:0]  status_o,
  output logic [4:0]  values_left_o
);
  localparam int OAW = $clog2(OP_DEPTH);
  localparam int OCW = $clog2(OP_DEPTH + 1);
  localparam int VAW = $clog2(VALUE_DEPTH);
  localparam int VCW = $clog2(VALUE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_LAST  = 10'b0000000100,
    S_OPRD  = 10'b0000001000,
    S_OPCHK = 10'b0000010000,
    S_POPA  = 10'b0000100000,
    S_POPW  = 10'b0001000000,
    S_EXEC  = 10'b0010000000,
    S_OUTRD = 10'b0100000000,
    S_OUTW  = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_OP    = 2'd0,
    MODE_RPAR  = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;
  logic [63:0]      acc_q, acc_d;
  logic             nin_q, nin_d, nign_q, nign_d;
  iee_pkg::status_e status_q, status_d;
  logic [VCW-1:0]   vcnt_q, vcnt_d;
  logic [OCW-1:0]   ocnt_q, ocnt_d;
  iee_pkg::op_e     pend_q, pend_d, cur_q, cur_d, top_op;
  logic [63:0]      rhs_q, rhs_d, lhs_q, lhs_d, pop_val;
  logic             second_q, second_d, vhit_q, vhit_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      out_res_q, out_res_d;
  logic [1:0]       out_st_q, out_st_d;
  logic [4:0]       out_vl_q, out_vl_d;

  logic             v_we, v_re, o_we, o_re;
  logic [VAW-1:0]   v_waddr, v_raddr;
  logic [OAW-1:0]   o_waddr, o_raddr;
  logic [63:0]      v_wdata, v_rdata, alu_res;
  logic [2:0]       o_wdata, o_rdata;
  iee_pkg::alu_req_t alu_req;
  iee_pkg::alu_rsp_t alu_rsp;

  logic [67:0]      num_ext, num_next;
  logic [3:0]       digit;
  logic             is_digit;
  logic [VCW+4:0]   vcnt_wide;

  iee_ram #(.WIDTH(64), .DEPTH(VALUE_DEPTH)) u_vram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(v_re), .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  iee_ram #(.WIDTH(3), .DEPTH(OP_DEPTH)) u_oram (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  iee_alu u_alu (
    .clk_i, .rst_ni, .req_i(alu_req), .lhs_i(lhs_q), .rhs_i(rhs_q),
    .rsp_o(alu_rsp), .result_o(alu_res)
  );

  // decimal accumulate: acc*10 + digit, checked against the signed limit
  assign is_digit  = (char_q >= iee_pkg::CH_ZERO) && (char_q <= iee_pkg::CH_NINE);
  assign digit     = 4'(char_q - iee_pkg::CH_ZERO);
  assign num_ext   = nin_q ? {4'd0, acc_q} : 68'd0;
  assign num_next  = (num_ext << 3) + (num_ext << 1) + {64'd0, digit};
  assign top_op    = iee_pkg::op_e'(o_rdata);
  assign pop_val   = vhit_q ? v_rdata : 64'd0;
  assign vcnt_wide = {5'd0, vcnt_q};

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    char_d      = char_q;
    last_d      = last_q;
    acc_d       = acc_q;
    nin_d       = nin_q;
    nign_d      = nign_q;
    status_d    = status_q;
    vcnt_d      = vcnt_q;
    ocnt_d      = ocnt_q;
    pend_d      = pend_q;
    cur_d       = cur_q;
    rhs_d       = rhs_q;
    lhs_d       = lhs_q;
    second_d    = second_q;
    vhit_d      = vhit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    out_vl_d    = out_vl_q;
    v_we        = 1'b0;
    v_waddr     = vcnt_q[VAW-1:0];
    v_wdata     = acc_q;
    v_re        = 1'b0;
    v_raddr     = VAW'(vcnt_q - VCW'(1));
    o_we        = 1'b0;
    o_waddr     = ocnt_q[OAW-1:0];
    o_wdata     = pend_q;
    o_re        = 1'b0;
    o_raddr     = OAW'(ocnt_q - OCW'(1));
    alu_req     = '{start: 1'b0, op: cur_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          char_d  = char_code_i;
          last_d  = last_i;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_LAST;
        if (is_digit) begin
          if (!nin_q) begin
            nign_d = 1'b0;
          end
          nin_d = 1'b1;
          if (!nin_q || !nign_q) begin
            if (num_next > iee_pkg::INT_LIMIT) begin
              acc_d  = '0;
              nign_d = 1'b1;
            end else begin
              acc_d = num_next[63:0];
            end
          end
        end else if (char_q == iee_pkg::CH_DOT) begin
          if (!nin_q) begin
            acc_d = '0;
          end
          nin_d  = 1'b1;
          nign_d = 1'b1;
        end else begin
          // any other character ends the number in progress
          if (nin_q) begin
            if (vcnt_q < VCW'(VALUE_DEPTH)) begin
              v_we   = 1'b1;
              vcnt_d = vcnt_q + VCW'(1);
            end else begin
              status_d = iee_pkg::raise(status_q, iee_pkg::ST_OVERFLOW);
            end
          end
          nin_d  = 1'b0;
          nign_d = 1'b0;
          acc_d  = '0;
          if (iee_pkg::char_to_op(char_q) != iee_pkg::OPC_NONE) begin
            pend_d  = iee_pkg::char_to_op(char_q);
            mode_d  = MODE_OP;
            state_d = S_OPRD;
          end else if (char_q == iee_pkg::CH_LPAREN) begin
            if (ocnt_q < OCW'(OP_DEPTH)) begin
              o_we    = 1'b1;
              o_wdata = iee_pkg::OPC_PAREN;
              ocnt_d  = ocnt_q + OCW'(1);
            end else begin
              status_d = iee_pkg::raise(status_d, iee_pkg::ST_OVERFLOW);
            end
          end else if (char_q == iee_pkg::CH_RPAREN) begin
            mode_d  = MODE_RPAR;
            state_d = S_OPRD;
          end
        end
      end
      S_LAST: begin
        if (last_q) begin
          if (nin_q) begin
            if (vcnt_q < VCW'(VALUE_DEPTH)) begin
              v_we   = 1'b1;
              vcnt_d = vcnt_q + VCW'(1);
            end else begin
              status_d = iee_pkg::raise(status_q, iee_pkg::ST_OVERFLOW);
            end
          end
          nin_d   = 1'b0;
          nign_d  = 1'b0;
          acc_d   = '0;
          mode_d  = MODE_FLUSH;
          state_d = S_OPRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OPRD: begin
        if (ocnt_q == '0) begin
          unique case (mode_q)
            MODE_OP: begin
              o_we    = 1'b1;
              ocnt_d  = ocnt_q + OCW'(1);
              state_d = S_LAST;
            end
            MODE_FLUSH: state_d = S_OUTRD;
            default:    state_d = S_LAST;
          endcase
        end else begin
          o_re    = 1'b1;
          state_d = S_OPCHK;
        end
      end
      S_OPCHK: begin
        unique case (mode_q)
          MODE_OP: begin
            if (top_op != iee_pkg::OPC_PAREN &&
                iee_pkg::prec(top_op) >= iee_pkg::prec(pend_q)) begin
              ocnt_d   = ocnt_q - OCW'(1);
              cur_d    = top_op;
              second_d = 1'b0;
              state_d  = S_POPA;
            end else begin
              if (ocnt_q < OCW'(OP_DEPTH)) begin
                o_we   = 1'b1;
                ocnt_d = ocnt_q + OCW'(1);
              end else begin
                status_d = iee_pkg::raise(status_q, iee_pkg::ST_OVERFLOW);
              end
              state_d = S_LAST;
            end
          end
          MODE_RPAR: begin
            ocnt_d = ocnt_q - OCW'(1);
            if (top_op != iee_pkg::OPC_PAREN) begin
              cur_d    = top_op;
              second_d = 1'b0;
              state_d  = S_POPA;
            end else begin
              state_d = S_LAST;
            end
          end
          default: begin
            ocnt_d = ocnt_q - OCW'(1);
            if (top_op != iee_pkg::OPC_PAREN) begin
              cur_d    = top_op;
              second_d = 1'b0;
              state_d  = S_POPA;
            end else begin
              state_d = S_OPRD;
            end
          end
        endcase
      end
      S_POPA: begin
        // empty value stack pops as zero
        if (vcnt_q != '0) begin
          v_re   = 1'b1;
          vcnt_d = vcnt_q - VCW'(1);
          vhit_d = 1'b1;
        end else begin
          vhit_d = 1'b0;
        end
        state_d = S_POPW;
      end
      S_POPW: begin
        if (!second_q) begin
          rhs_d    = pop_val;
          second_d = 1'b1;
          state_d  = S_POPA;
        end else begin
          lhs_d   = pop_val;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (second_q) begin
          alu_req.start = 1'b1;
          second_d      = 1'b0;
        end else if (alu_rsp.done) begin
          if (alu_rsp.div_zero) begin
            status_d = iee_pkg::raise(status_d, iee_pkg::ST_DIV_ZERO);
          end
          if (cur_q == iee_pkg::OPC_DICE) begin
            status_d = iee_pkg::raise(status_d, iee_pkg::ST_DICE);
          end
          v_wdata = alu_res;
          if (vcnt_q < VCW'(VALUE_DEPTH)) begin
            v_we   = 1'b1;
            vcnt_d = vcnt_q + VCW'(1);
          end else begin
            status_d = iee_pkg::raise(status_d, iee_pkg::ST_OVERFLOW);
          end
          state_d = S_OPRD;
        end
      end
      S_OUTRD: begin
        v_re    = vcnt_q != '0;
        vhit_d  = vcnt_q != '0;
        state_d = S_OUTW;
      end
      S_OUTW: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = pop_val;
          out_st_d    = status_q;
          out_vl_d    = vcnt_wide[4:0];
          vcnt_d      = '0;
          ocnt_d      = '0;
          status_d    = iee_pkg::ST_OK;
          nin_d       = 1'b0;
          nign_d      = 1'b0;
          acc_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_OP;
      acc_q       <= '0;
      nin_q       <= 1'b0;
      nign_q      <= 1'b0;
      status_q    <= iee_pkg::ST_OK;
      vcnt_q      <= '0;
      ocnt_q      <= '0;
      second_q    <= 1'b0;
      vhit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      nin_q       <= nin_d;
      nign_q      <= nign_d;
      status_q    <= status_d;
      vcnt_q      <= vcnt_d;
      ocnt_q      <= ocnt_d;
      second_q    <= second_d;
      vhit_q      <= vhit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q    <= char_d;
    last_q    <= last_d;
    pend_q    <= pend_d;
    cur_q     <= cur_d;
    rhs_q     <= rhs_d;
    lhs_q     <= lhs_d;
    out_res_q <= out_res_d;
    out_st_q  <= out_st_d;
    out_vl_q  <= out_vl_d;
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign result_o      = out_res_q;
  assign status_o      = out_st_q;
  assign values_left_o = out_vl_q;

  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= VCW'(VALUE_DEPTH)) else $error("value count past depth");
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OCW'(OP_DEPTH)) else $error("operator count past depth");
  a_alu_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_EXEC) else $error("alu result outside execute");
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != iee_pkg::ST_OK && state_q != S_OUTW) |=> $stable(status_q))
    else $error("status overwritten");
endmodule

// ===== tb/infix_expression_evaluator_tb.sv =====
// Testbench for the infix expression evaluator: directed and random expressions.
`timescale 1ns / 1ps
module infix_expression_evaluator_tb;

  localparam int STK_DEPTH = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_code_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_o;
  logic [1:0]  status_o;
  logic [4:0]  values_left_o;

  infix_expression_evaluator DUT (.*);

  typedef struct {
    logic [63:0]      value;
    iee_pkg::status_e status;
    logic [4:0]       depth;
  } eval_result_t;

  eval_result_t expected_results[$];
  int           fail_count;
  bit           out_idle_enable;
  bit           in_idle_enable;

  // Predictor state
  iee_pkg::op_e     pr_ops[STK_DEPTH];
  int               pr_op_cnt;
  logic [63:0]      pr_vals[STK_DEPTH];
  int               pr_val_cnt;
  logic [63:0]      pr_acc;
  bit               pr_in_num;
  bit               pr_ignore;
  iee_pkg::status_e pr_status;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("infix_expression_evaluator_tb: errors");
    $finish;
  end

  function automatic void pr_clear();
    pr_op_cnt = 0;
    pr_val_cnt = 0;
    pr_acc = '0;
    pr_in_num = 0;
    pr_ignore = 0;
    pr_status = iee_pkg::ST_OK;
  endfunction

  function automatic void pr_flag(iee_pkg::status_e s);
    if (pr_status == iee_pkg::ST_OK) pr_status = s;
  endfunction

  function automatic void pr_push_val(logic [63:0] v);
    if (pr_val_cnt < STK_DEPTH) begin
      pr_vals[pr_val_cnt] = v;
      pr_val_cnt++;
    end else pr_flag(iee_pkg::ST_OVERFLOW);
  endfunction

  function automatic logic [63:0] pr_pop_val();
    if (pr_val_cnt == 0) return '0;
    pr_val_cnt--;
    return pr_vals[pr_val_cnt];
  endfunction

  function automatic int op_rank(iee_pkg::op_e o);
    unique case (o)
      iee_pkg::OPC_ADD, iee_pkg::OPC_SUB: return 2;
      iee_pkg::OPC_MUL, iee_pkg::OPC_DIV: return 3;
      iee_pkg::OPC_XOR:                   return 4;
      iee_pkg::OPC_DICE:                  return 5;
      default:                            return 1;
    endcase
  endfunction

  function automatic void pr_apply(iee_pkg::op_e o);
    logic [63:0] rhs, lhs, r, ua, ub, q;
    rhs = pr_pop_val();
    lhs = pr_pop_val();
    r = '0;
    unique case (o)
      iee_pkg::OPC_ADD: r = lhs + rhs;
      iee_pkg::OPC_SUB: r = lhs - rhs;
      iee_pkg::OPC_MUL: r = lhs * rhs;
      iee_pkg::OPC_DIV: begin
        if (rhs == 0) pr_flag(iee_pkg::ST_DIV_ZERO);
        else begin
          // magnitude divide; min / -1 wraps back to min
          ua = lhs[63] ? -lhs : lhs;
          ub = rhs[63] ? -rhs : rhs;
          q = ua / ub;
          r = (lhs[63] != rhs[63]) ? -q : q;
        end
      end
      iee_pkg::OPC_XOR:  r = lhs ^ rhs;
      iee_pkg::OPC_DICE: pr_flag(iee_pkg::ST_DICE);
      default: ;
    endcase
    pr_push_val(r);
  endfunction

  function automatic void pr_end_number();
    if (pr_in_num) pr_push_val(pr_acc);
    pr_in_num = 0;
    pr_ignore = 0;
    pr_acc = '0;
  endfunction

  function automatic void pr_push_op(iee_pkg::op_e o);
    if (pr_op_cnt < STK_DEPTH) begin
      pr_ops[pr_op_cnt] = o;
      pr_op_cnt++;
    end else pr_flag(iee_pkg::ST_OVERFLOW);
  endfunction

  // Advance the predictor by one character; queue a result on the last one.
  function automatic void predict_char(logic [7:0] c, logic fin);
    iee_pkg::op_e o;
    logic [63:0]  dg;
    eval_result_t res;
    o = iee_pkg::char_to_op(c);
    if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
      if (!pr_in_num) begin
        pr_in_num = 1;
        pr_acc = '0;
      end
      if (!pr_ignore) begin
        dg = 64'(c - iee_pkg::CH_ZERO);
        if (pr_acc > (64'h7FFF_FFFF_FFFF_FFFF - dg) / 10) begin
          pr_acc = '0;
          pr_ignore = 1;
        end else pr_acc = pr_acc * 10 + dg;
      end
    end else if (c == iee_pkg::CH_DOT) begin
      if (!pr_in_num) begin
        pr_in_num = 1;
        pr_acc = '0;
      end
      pr_ignore = 1;
    end else begin
      pr_end_number();
      if (o != iee_pkg::OPC_NONE) begin
        while (pr_op_cnt > 0 && pr_ops[pr_op_cnt-1] != iee_pkg::OPC_PAREN &&
               op_rank(pr_ops[pr_op_cnt-1]) >= op_rank(o)) begin
          pr_op_cnt--;
          pr_apply(pr_ops[pr_op_cnt]);
        end
        pr_push_op(o);
      end else if (c == iee_pkg::CH_LPAREN) pr_push_op(iee_pkg::OPC_PAREN);
      else if (c == iee_pkg::CH_RPAREN) begin
        while (pr_op_cnt > 0 && pr_ops[pr_op_cnt-1] != iee_pkg::OPC_PAREN) begin
          pr_op_cnt--;
          pr_apply(pr_ops[pr_op_cnt]);
        end
        if (pr_op_cnt > 0) pr_op_cnt--;
      end
    end
    if (!fin) return;
    pr_end_number();
    while (pr_op_cnt > 0) begin
      pr_op_cnt--;
      if (pr_ops[pr_op_cnt] != iee_pkg::OPC_PAREN) pr_apply(pr_ops[pr_op_cnt]);
    end
    res.value = pr_val_cnt ? pr_vals[pr_val_cnt-1] : '0;
    res.status = pr_status;
    res.depth = 5'(pr_val_cnt);
    expected_results = {expected_results, res};
    pr_clear();
  endfunction

  // Send one character; the prediction is made as the transfer happens.
  // Valid stays high after a transfer until the next call idles or the sender drains.
  task automatic send_char(logic [7:0] c, logic fin);
    while (in_idle_enable && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    last_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_char(c, fin);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    eval_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", result_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (result_o !== e.value) begin
          $error("result: expected %h actual %h", e.value, result_o);
          fail_count++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o);
          fail_count++;
        end
        if (values_left_o !== e.depth) begin
          $error("values_left: expected %0d actual %0d", e.depth, values_left_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= out_idle_enable && ($urandom_range(99) < 11);
  end

  task automatic test_directed();
    send_string("1+2");
    send_string("7-10");
    send_string("2+3*4");
    send_string("(2+3)*4");
    send_string("100/7");
    send_string("0-100/7");
    send_string("5/0");
    send_string("6^3*2");
    send_string("3d4+1");
    send_string(".");
    send_string(".57+3.9");
    send_string("9223372036854775807+1");
    send_string("9223372036854775808");
    send_string("18446744073709551615*3");
    send_string("0-9223372036854775807-1/(0-1)");
    send_string("(0-9223372036854775807-1)/(0-1)");
    send_string("+");
    send_string("1 2 3");
    send_string("2))*3");
    send_string("((((4");
    send_string("1+2+3+4+5+6+7+8+9+10+11+12+13+14+15+16+17");
    send_string("((((((((((((((((((1");
    send_string("1^2^3^4^5^6^7^8^9^1^2^3^4^5^6^7^8^9^1");
    send_string("9-3-2");
    send_char(8'hFF, 1'b1);
  endtask

  function automatic logic [7:0] rand_op_char();
    unique case ($urandom_range(5))
      0: return iee_pkg::CH_PLUS;
      1: return iee_pkg::CH_MINUS;
      2: return iee_pkg::CH_STAR;
      3: return iee_pkg::CH_SLASH;
      4: return iee_pkg::CH_CARET;
      default: return ($urandom_range(19) == 0) ? iee_pkg::CH_DICE : iee_pkg::CH_PLUS;
    endcase
  endfunction

  // Mostly well-formed expressions with random numbers and nesting; some noise.
  task automatic test_random(int n_chars);
    int sent, terms, depth, nd;
    string s;
    sent = 0;
    while (sent < n_chars) begin
      s = "";
      if ($urandom_range(9) == 0) begin
        terms = $urandom_range(1, 12);
        for (int i = 0; i < terms; i++) s = {s, string'(8'($urandom_range(255)))};
      end else begin
        terms = $urandom_range(1, 6);
        depth = 0;
        for (int i = 0; i < terms; i++) begin
          if ($urandom_range(3) == 0) begin
            s = {s, "("};
            depth++;
          end
          nd = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
          for (int k = 0; k < nd; k++) begin
            s = {s, string'(8'(iee_pkg::CH_ZERO + $urandom_range(9)))};
          end
          if ($urandom_range(15) == 0) s = {s, "."};
          if (depth > 0 && $urandom_range(2) == 0) begin
            s = {s, ")"};
            depth--;
          end
          if (i != terms - 1) s = {s, string'(rand_op_char())};
        end
        while (depth > 0 && $urandom_range(4) != 0) begin
          s = {s, ")"};
          depth--;
        end
      end
      send_string(s);
      sent += s.len();
    end
  endtask

  initial begin
    fail_count = 0;
    in_valid_i = 1'b0;
    char_code_i = '0;
    last_i = 1'b0;
    out_stall_i = 1'b0;
    out_idle_enable = 1'b0;
    in_idle_enable = 1'b0;
    pr_clear();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    out_idle_enable = 1'b1;
    in_idle_enable = 1'b1;
    test_random(500);
    wait_drained();
    in_idle_enable = 1'b0;
    out_idle_enable = 1'b0;
    test_random(150);
    in_idle_enable = 1'b1;
    out_idle_enable = 1'b1;
    test_random(450);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("infix_expression_evaluator_tb: clean");
    end else begin
      $display("infix_expression_evaluator_tb: errors");
    end
    $finish;
  end

endmodule
